// File: rtl/hca_pkg.sv
// ----------------------------------------------------------------------------
// hca_pkg: shared types and constants for the hybrid CA polynomial block
// Rule codes, dependence decode type, result status codes and sizes.
// ----------------------------------------------------------------------------
package hca_pkg;

  // Largest number of cells that enter the polynomial.
  localparam int unsigned MaxCells = 63;

  localparam int unsigned RuleW  = 8;
  localparam int unsigned PolyW  = 64;
  localparam int unsigned CountW = 6;

  // The eight linear rules.
  localparam logic [RuleW-1:0] Rule0   = 8'd0;
  localparam logic [RuleW-1:0] Rule60  = 8'd60;
  localparam logic [RuleW-1:0] Rule90  = 8'd90;
  localparam logic [RuleW-1:0] Rule102 = 8'd102;
  localparam logic [RuleW-1:0] Rule150 = 8'd150;
  localparam logic [RuleW-1:0] Rule170 = 8'd170;
  localparam logic [RuleW-1:0] Rule204 = 8'd204;
  localparam logic [RuleW-1:0] Rule240 = 8'd240;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StInvalid  = 2'd1,
    StOverflow = 2'd2
  } status_t;

  // Decoded rule: whether it is linear, and its self, left and right terms.
  typedef struct packed {
    logic valid;
    logic dep_self;
    logic dep_left;
    logic dep_right;
  } rule_dec_t;

endpackage

// File: rtl/hca_rule_dec.sv
// ----------------------------------------------------------------------------
// hca_rule_dec: linear rule decoder
// Maps a rule number to its neighbor dependence bits, flags other rules.
// ----------------------------------------------------------------------------
module hca_rule_dec (
  input  logic [hca_pkg::RuleW-1:0] rule_code,
  output hca_pkg::rule_dec_t        dec
);

  always_comb begin
    dec = '0;
    case (rule_code)
      hca_pkg::Rule0: begin
        dec.valid = 1'b1;
      end
      hca_pkg::Rule60: begin
        dec = '{valid: 1'b1, dep_self: 1'b1, dep_left: 1'b1, dep_right: 1'b0};
      end
      hca_pkg::Rule90: begin
        dec = '{valid: 1'b1, dep_self: 1'b0, dep_left: 1'b1, dep_right: 1'b1};
      end
      hca_pkg::Rule102: begin
        dec = '{valid: 1'b1, dep_self: 1'b1, dep_left: 1'b0, dep_right: 1'b1};
      end
      hca_pkg::Rule150: begin
        dec = '{valid: 1'b1, dep_self: 1'b1, dep_left: 1'b1, dep_right: 1'b1};
      end
      hca_pkg::Rule170: begin
        dec = '{valid: 1'b1, dep_self: 1'b0, dep_left: 1'b0, dep_right: 1'b1};
      end
      hca_pkg::Rule204: begin
        dec = '{valid: 1'b1, dep_self: 1'b1, dep_left: 1'b0, dep_right: 1'b0};
      end
      hca_pkg::Rule240: begin
        dec = '{valid: 1'b1, dep_self: 1'b0, dep_left: 1'b1, dep_right: 1'b0};
      end
      default: begin
        dec = '0;
      end
    endcase
  end

endmodule

// File: rtl/hybrid_ca_char_poly.sv
// ----------------------------------------------------------------------------
// hybrid_ca_char_poly: characteristic polynomial of a hybrid linear CA
// Builds the GF(2) characteristic polynomial of a null-boundary hybrid
// cellular automaton from one rule number per cell request.
// ----------------------------------------------------------------------------
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------
//   in_      | slave     | tdata: rule_code[7:0]; tlast: last_cell
//   out_     | master    | tdata: char_poly[63:0], poly_degree[69:64],
//            |           |        zero pad[71:70]; tuser: status[1:0]
//
// Each cell request is held in the input register, where the rule is decoded
// and the continuant recurrence (one shift and two XORs over the 64-bit
// polynomial) updates the state; a result moves to the output register in
// that same cycle. A new request is taken every cycle unless a request that
// yields a result waits on a busy output. A last cell passes the input, then the output register.
// Reset (rst_n low, synchronous) empties both registers and restores the
// constant polynomial. Only requests that produce a result wait on a
// stalled output; ordinary cells keep flowing while a result sits unclaimed.
// ----------------------------------------------------------------------------
module hybrid_ca_char_poly (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rule_code
  input  logic        in_tlast,   // last_cell

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] char_poly, [69:64] poly_degree, [71:70] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned PolyW  = hca_pkg::PolyW;
  localparam int unsigned CountW = hca_pkg::CountW;

  // Input register.
  logic                     in_v_r,    in_v_nxt;
  logic [hca_pkg::RuleW-1:0] in_rule_r, in_rule_nxt;
  logic                     in_last_r, in_last_nxt;

  // Recurrence state.
  logic [PolyW-1:0]  cur_poly_r,  cur_poly_nxt;
  logic [PolyW-1:0]  prev_poly_r, prev_poly_nxt;
  logic              right_dep_r, right_dep_nxt;
  logic [CountW-1:0] cell_count_r, cell_count_nxt;
  logic              ovf_r,       ovf_nxt;

  // Output register.
  logic              out_v_r,      out_v_nxt;
  logic [PolyW-1:0]  out_poly_r,   out_poly_nxt;
  logic [CountW-1:0] out_degree_r, out_degree_nxt;
  hca_pkg::status_t  out_status_r, out_status_nxt;

  hca_pkg::rule_dec_t dec;

  logic              needs_out;
  logic              out_free;
  logic              advance;
  logic              room;
  logic [PolyW-1:0]  upd_poly;
  logic [PolyW-1:0]  upd_prev;
  logic              upd_right;
  logic [CountW-1:0] upd_count;
  logic              upd_ovf;

  hca_rule_dec u_rule_dec (
    .rule_code (in_rule_r),
    .dec       (dec)
  );

  // A held request needs the output slot only if it yields a result: a
  // rejected rule or the last cell of an automaton.
  assign needs_out = in_v_r && (!dec.valid || in_last_r);
  assign out_free  = !out_v_r || out_tready;
  assign advance   = in_v_r && (!needs_out || out_free);
  assign in_tready = !in_v_r || advance;

  always_comb begin
    in_v_nxt    = in_v_r;
    in_rule_nxt = in_rule_r;
    in_last_nxt = in_last_r;
    if (in_tready) begin
      in_v_nxt    = in_tvalid;
      in_rule_nxt = in_tdata;
      in_last_nxt = in_tlast;
    end
  end

  // One step of the continuant recurrence:
  //   new = (x + self) * cur  XOR  (prior right AND this left ? prev : 0)
  // Cells past the limit leave the polynomial alone and mark overflow.
  assign room = cell_count_r < CountW'(hca_pkg::MaxCells);

  always_comb begin
    upd_poly  = cur_poly_r;
    upd_prev  = prev_poly_r;
    upd_right = right_dep_r;
    upd_count = cell_count_r;
    upd_ovf   = ovf_r;
    if (room) begin
      upd_poly = {cur_poly_r[PolyW-2:0], 1'b0};
      if (dec.dep_self) begin
        upd_poly = upd_poly ^ cur_poly_r;
      end
      if (right_dep_r && dec.dep_left) begin
        upd_poly = upd_poly ^ prev_poly_r;
      end
      upd_prev  = cur_poly_r;
      upd_right = dec.dep_right;
      upd_count = cell_count_r + CountW'(1);
    end else begin
      upd_ovf = 1'b1;
    end
  end

  always_comb begin
    cur_poly_nxt   = cur_poly_r;
    prev_poly_nxt  = prev_poly_r;
    right_dep_nxt  = right_dep_r;
    cell_count_nxt = cell_count_r;
    ovf_nxt        = ovf_r;
    if (advance && dec.valid) begin
      if (in_last_r) begin
        // The automaton is complete; start over for the next one.
        cur_poly_nxt   = PolyW'(1);
        prev_poly_nxt  = '0;
        right_dep_nxt  = 1'b0;
        cell_count_nxt = '0;
        ovf_nxt        = 1'b0;
      end else begin
        cur_poly_nxt   = upd_poly;
        prev_poly_nxt  = upd_prev;
        right_dep_nxt  = upd_right;
        cell_count_nxt = upd_count;
        ovf_nxt        = upd_ovf;
      end
    end
  end

  always_comb begin
    out_v_nxt      = out_v_r;
    out_poly_nxt   = out_poly_r;
    out_degree_nxt = out_degree_r;
    out_status_nxt = out_status_r;
    if (out_tready) begin
      out_v_nxt = 1'b0;
    end
    if (advance && needs_out) begin
      out_v_nxt = 1'b1;
      if (!dec.valid) begin
        // A rejected rule leaves the state untouched and reports zeros.
        out_poly_nxt   = '0;
        out_degree_nxt = '0;
        out_status_nxt = hca_pkg::StInvalid;
      end else begin
        out_poly_nxt   = upd_poly;
        out_degree_nxt = upd_count;
        out_status_nxt = upd_ovf ? hca_pkg::StOverflow : hca_pkg::StOk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      cur_poly_r   <= PolyW'(1);
      prev_poly_r  <= '0;
      right_dep_r  <= 1'b0;
      cell_count_r <= '0;
      ovf_r        <= 1'b0;
    end else begin
      in_v_r       <= in_v_nxt;
      out_v_r      <= out_v_nxt;
      cur_poly_r   <= cur_poly_nxt;
      prev_poly_r  <= prev_poly_nxt;
      right_dep_r  <= right_dep_nxt;
      cell_count_r <= cell_count_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_rule_r    <= in_rule_nxt;
    in_last_r    <= in_last_nxt;
    out_poly_r   <= out_poly_nxt;
    out_degree_r <= out_degree_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_degree_r, out_poly_r};
  assign out_tuser  = out_status_r;

  // A rejected rule always reports an empty polynomial.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_status_r == hca_pkg::StInvalid) |-> (out_poly_r == '0) &&
    (out_degree_r == '0))
    else $error("rejected rule result carries a nonzero polynomial");

  // The characteristic polynomial is monic with the reported degree.
  a_monic: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_status_r != hca_pkg::StInvalid) |-> out_poly_r[out_degree_r])
    else $error("result polynomial lacks its leading coefficient");

  // With no cell taken the recurrence sits at its starting values.
  a_fresh_state: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_count_r == '0) |-> (cur_poly_r == PolyW'(1)) && (prev_poly_r == '0) &&
    !right_dep_r)
    else $error("recurrence state not at its start with zero cells");

  // A held request only stalls when it needs a busy output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_v_r && needs_out && out_v_r && !out_tready)
    else $error("input stalled without a pending result");

endmodule

// File: dv/tb_hybrid_ca_char_poly.sv
// ----------------------------------------------------------------------------
// tb_hybrid_ca_char_poly: self-checking bench for the hybrid CA polynomial
// Streams rule numbers, one cell per request, into the block and predicts
// each result with a cycle-free GF(2) continuant model kept in the bench.
// Every result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_hybrid_ca_char_poly;

  localparam int unsigned PolyW    = hca_pkg::PolyW;
  localparam int unsigned CountW   = hca_pkg::CountW;
  localparam int unsigned RuleW    = hca_pkg::RuleW;
  localparam int unsigned MaxCells = hca_pkg::MaxCells;

  // Generous run limit in clock cycles; the slowest legal run is far shorter.
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RandomCells = 1150;
  localparam int unsigned MaxPrinted = 50;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] rule_code
  logic        in_tlast = 1'b0; // last_cell

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // [63:0] char_poly, [69:64] poly_degree, [71:70] zero
  logic [1:0]  out_tuser;       // [1:0] status

  hybrid_ca_char_poly u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One expected result: the polynomial, its degree and the status code.
  typedef struct {
    logic [PolyW-1:0]  poly;
    logic [CountW-1:0] degree;
    hca_pkg::status_t  status;
  } poly_result_t;

  poly_result_t pending_polys[$];

  // Predictor state: the two most recent continuants and the bookkeeping
  // that the block keeps between cells of one automaton.
  logic [PolyW-1:0]  cont_cur;
  logic [PolyW-1:0]  cont_prev;
  logic              prev_right_dep;
  logic [CountW-1:0] cells_taken;
  logic              cells_dropped;

  // Stimulus and bookkeeping knobs.
  bit          in_gaps_on = 1'b1;
  bit          out_gaps_on = 1'b1;
  int unsigned hold_left = 0;
  int unsigned cells_sent = 0;
  int unsigned results_seen = 0;
  int unsigned invalid_seen = 0;
  int unsigned overflow_seen = 0;
  int unsigned in_stall_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  logic [RuleW-1:0] linear_rules [8];

  initial begin
    linear_rules = '{hca_pkg::Rule0, hca_pkg::Rule60, hca_pkg::Rule90, hca_pkg::Rule102,
                     hca_pkg::Rule150, hca_pkg::Rule170, hca_pkg::Rule204,
                     hca_pkg::Rule240};
  end

  // Splits a rule number into its self, left and right dependence bits.
  // Anything outside the eight linear rules comes back with valid low.
  function automatic hca_pkg::rule_dec_t decode_cell_rule(logic [RuleW-1:0] code);
    hca_pkg::rule_dec_t d;
    d = '0;
    d.valid = 1'b1;
    case (code)
      hca_pkg::Rule0:   ;
      hca_pkg::Rule60:  begin d.dep_self = 1'b1; d.dep_left = 1'b1; end
      hca_pkg::Rule90:  begin d.dep_left = 1'b1; d.dep_right = 1'b1; end
      hca_pkg::Rule102: begin d.dep_self = 1'b1; d.dep_right = 1'b1; end
      hca_pkg::Rule150: begin
        d.dep_self = 1'b1; d.dep_left = 1'b1; d.dep_right = 1'b1;
      end
      hca_pkg::Rule170: d.dep_right = 1'b1;
      hca_pkg::Rule204: d.dep_self = 1'b1;
      hca_pkg::Rule240: d.dep_left = 1'b1;
      default: d.valid = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [RuleW-1:0] pick_invalid_rule();
    logic [RuleW-1:0]   code;
    hca_pkg::rule_dec_t d;
    do begin
      code = RuleW'($urandom_range(255));
      d = decode_cell_rule(code);
    end while (d.valid);
    return code;
  endfunction

  task automatic restart_automaton();
    cont_cur = PolyW'(1);
    cont_prev = '0;
    prev_right_dep = 1'b0;
    cells_taken = '0;
    cells_dropped = 1'b0;
  endtask

  // Advances the continuant recurrence for one accepted request and queues
  // the result it produces, if any.
  task automatic update_continuant(logic [RuleW-1:0] code, logic is_last);
    hca_pkg::rule_dec_t d;
    logic [PolyW-1:0]   nxt;
    poly_result_t       r;
    d = decode_cell_rule(code);
    if (!d.valid) begin
      // A rejected rule leaves the automaton untouched, last mark and all.
      r.poly = '0;
      r.degree = '0;
      r.status = hca_pkg::StInvalid;
      pending_polys.push_back(r);
      return;
    end
    if (cells_taken < MaxCells) begin
      nxt = cont_cur << 1;
      if (d.dep_self) nxt ^= cont_cur;
      if (prev_right_dep && d.dep_left) nxt ^= cont_prev;
      cont_prev = cont_cur;
      cont_cur = nxt;
      prev_right_dep = d.dep_right;
      cells_taken = cells_taken + 1'b1;
    end else begin
      // The automaton is already full; the cell only marks the overflow.
      cells_dropped = 1'b1;
    end
    if (is_last) begin
      r.poly = cont_cur;
      r.degree = cells_taken;
      r.status = cells_dropped ? hca_pkg::StOverflow : hca_pkg::StOk;
      pending_polys.push_back(r);
      restart_automaton();
    end
  endtask

  task automatic report_mismatch(string field, logic [PolyW-1:0] got, logic [PolyW-1:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
               cycle_count, field, got, want);
  endtask

  // Offers one cell request at a falling edge and holds it until the block
  // takes it. Random gaps with tvalid low may come first. tvalid is left
  // high after acceptance; the next call or the drain task moves it.
  task automatic send_cell(logic [RuleW-1:0] code, logic is_last);
    @(negedge clk);
    while (in_gaps_on && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= code;
    in_tlast <= is_last;
    do @(posedge clk); while (!in_tready);
    update_continuant(code, is_last);
    cells_sent++;
  endtask

  // Sends one automaton of n_cells linear cells, with an invalid rule slipped
  // in before a cell noise_pct percent of the time.
  task automatic send_automaton(int unsigned n_cells, int unsigned noise_pct);
    for (int unsigned i = 0; i < n_cells; i++) begin
      if ($urandom_range(99) < noise_pct)
        send_cell(pick_invalid_rule(), 1'($urandom_range(1)));
      send_cell(linear_rules[$urandom_range(7)], i == n_cells - 1);
    end
  endtask

  // Drops tvalid and waits until every predicted result has come out, then
  // keeps waiting on so that a stray result would still be caught.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_polys.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Each rule alone, then short chains where a right dependence meets a
  // left one so that the older continuant enters the sum.
  task automatic test_each_rule();
    foreach (linear_rules[i]) send_cell(linear_rules[i], 1'b1);
    send_cell(hca_pkg::Rule150, 1'b0);
    send_cell(hca_pkg::Rule150, 1'b1);
    send_cell(hca_pkg::Rule90, 1'b0);
    send_cell(hca_pkg::Rule90, 1'b1);
    drain_results();
  endtask

  // Rejected rules at both ends of the code range, with and without the
  // last mark, including one that lands inside an automaton and must not
  // close it.
  task automatic test_invalid_rules();
    send_cell(8'hFF, 1'b1);
    send_cell(8'h01, 1'b0);
    send_cell(hca_pkg::Rule102, 1'b0);
    send_cell(8'd59, 1'b1);
    send_cell(hca_pkg::Rule240, 1'b1);
    drain_results();
  endtask

  // A full automaton of exactly MaxCells cells, then ones that run past the
  // limit: once with extra cells before the last, once where only the last
  // cell is beyond it.
  task automatic test_overflow();
    send_automaton(MaxCells, 0);
    send_automaton(MaxCells + 7, 3);
    send_automaton(MaxCells + 1, 0);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while every request yields a result
  // (single-cell automata and some rejected rules), so results pile up and the input must stall.
  task automatic test_output_backpressure();
    in_gaps_on = 1'b0;
    hold_left = 400;
    for (int i = 0; i < 40; i++) begin
      if (i % 5 == 4) send_cell(pick_invalid_rule(), 1'b1);
      else send_cell(linear_rules[$urandom_range(7)], 1'b1);
    end
    in_gaps_on = 1'b1;
    drain_results();
  endtask

  // Random automata, mostly short, some long, a few running to or past the limit.
  task automatic run_random_automata(int unsigned cell_budget);
    int unsigned start;
    int unsigned pick;
    int unsigned n_cells;
    start = cells_sent;
    while (cells_sent - start < cell_budget) begin
      pick = $urandom_range(99);
      if (pick < 78) n_cells = $urandom_range(8, 1);
      else if (pick < 95) n_cells = $urandom_range(40, 9);
      else if (pick < 98) n_cells = $urandom_range(MaxCells, 41);
      else n_cells = $urandom_range(MaxCells + 4, MaxCells + 1);
      send_automaton(n_cells, 5);
    end
    drain_results();
  endtask

  // A stretch with no idling on either side.
  task automatic test_full_rate();
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    run_random_automata(250);
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  // Receiver: ready changes at the falling edge. A requested hold-off is
  // counted down here, cycle by cycle.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (out_gaps_on) begin
      out_tready <= ($urandom_range(99) >= 23);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    poly_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_polys.size() == 0) begin
        report_mismatch("unexpected result, char_poly", out_tdata[63:0], '0);
      end else begin
        want = pending_polys.pop_front();
        if (want.status == hca_pkg::StInvalid) invalid_seen++;
        if (want.status == hca_pkg::StOverflow) overflow_seen++;
        if (out_tdata[63:0] !== want.poly)
          report_mismatch("char_poly", out_tdata[63:0], want.poly);
        if (out_tdata[69:64] !== want.degree)
          report_mismatch("poly_degree", PolyW'(out_tdata[69:64]), PolyW'(want.degree));
        if (out_tdata[71:70] !== 2'b00)
          report_mismatch("tdata pad", PolyW'(out_tdata[71:70]), '0);
        if (out_tuser !== want.status)
          report_mismatch("status", PolyW'(out_tuser), PolyW'(want.status));
      end
    end
  end

  // Cycle counter, input stall counter and the run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && in_tvalid && !in_tready) in_stall_cycles++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_polys.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    restart_automaton();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_each_rule();
    test_invalid_rules();
    test_overflow();
    test_output_backpressure();
    test_full_rate();
    run_random_automata(RandomCells);

    $display("covered %0d cell requests and %0d results (%0d rejected rules, %0d overflows)",
             cells_sent, results_seen, invalid_seen, overflow_seen);
    $display("input stalled for %0d cycles under output back-pressure", in_stall_cycles);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/hca_pkg.sv
rtl/hca_rule_dec.sv
rtl/hybrid_ca_char_poly.sv
dv/tb_hybrid_ca_char_poly.sv
